>>> rtl/core/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int unsigned BundleBytes = 4;
    localparam int unsigned QueueDepth  = 2;
    localparam int unsigned QueueAw     = $clog2(QueueDepth);
    localparam int unsigned QueueCw     = $clog2(QueueDepth + 1);

    // A group of unescaped bytes caused by one input byte.
    typedef struct packed {
        logic [BundleBytes-1:0][7:0] data;
        logic [2:0]                  count;
        logic                        last;
    } bundle_t;

endpackage

>>> rtl/core/jsu_front.sv
// Input stage: escape decoding state machine that turns each byte into a bundle.
`timescale 1ns / 1ps

module jsu_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             push,
    output jsu_pkg::bundle_t push_data,
    input  logic             queue_ready
);

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } mode_t;

    // Returns {valid, value} for an ASCII hex digit of either case.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            ChB:     r = 8'h08;
            ChF:     r = 8'h0C;
            ChN:     r = 8'h0A;
            ChR:     r = 8'h0D;
            ChT:     r = 8'h09;
            default: r = b;
        endcase
        return r;
    endfunction

    mode_t            mode_reg, mode_next;
    logic [1:0]       seen_reg, seen_next;
    logic [11:0]      acc_reg, acc_next;
    logic [2:0][7:0]  hex_reg;
    logic             hex_wr;
    logic [4:0]       hv;
    logic [15:0]      cp;
    logic             accept;
    jsu_pkg::bundle_t bnd;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign hv       = hex_value(in_byte);
    assign cp       = {acc_reg, hv[3:0]};

    always_comb begin
        mode_next = mode_reg;
        seen_next = seen_reg;
        acc_next  = acc_reg;
        hex_wr    = 1'b0;
        bnd       = '0;
        bnd.last  = in_last;
        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_TEXT;
                if (in_byte == ChU) begin
                    if (!in_last) begin
                        mode_next = MODE_HEX;
                        seen_next = 2'd0;
                        acc_next  = 12'd0;
                    end
                end else begin
                    bnd.data[0] = escape_map(in_byte);
                    bnd.count   = 3'd1;
                end
            end
            MODE_HEX: begin
                if (!hv[4] || (in_last && seen_reg != 2'd3)) begin
                    // The escape is dropped: digits taken so far go out as text.
                    for (int i = 0; i < 3; i++) begin
                        bnd.data[i] = (3'(i) < {1'b0, seen_reg}) ? hex_reg[i] : in_byte;
                    end
                    bnd.data[3] = in_byte;
                    mode_next   = MODE_TEXT;
                    seen_next   = 2'd0;
                    acc_next    = 12'd0;
                    if (!hv[4] && in_byte == ChBslash && !in_last) begin
                        mode_next = MODE_ESC;
                        bnd.count = {1'b0, seen_reg};
                    end else begin
                        bnd.count = {1'b0, seen_reg} + 3'd1;
                    end
                end else if (seen_reg == 2'd3) begin
                    mode_next = MODE_TEXT;
                    seen_next = 2'd0;
                    acc_next  = 12'd0;
                    if (cp[15:7] == 9'd0) begin
                        bnd.data[0] = cp[7:0];
                        bnd.count   = 3'd1;
                    end else if (cp[15:11] == 5'd0) begin
                        bnd.data[0] = {3'b110, cp[10:6]};
                        bnd.data[1] = {2'b10, cp[5:0]};
                        bnd.count   = 3'd2;
                    end else begin
                        bnd.data[0] = {4'b1110, cp[15:12]};
                        bnd.data[1] = {2'b10, cp[11:6]};
                        bnd.data[2] = {2'b10, cp[5:0]};
                        bnd.count   = 3'd3;
                    end
                end else begin
                    hex_wr    = 1'b1;
                    acc_next  = {acc_reg[7:0], hv[3:0]};
                    seen_next = seen_reg + 2'd1;
                end
            end
            default: begin
                mode_next = MODE_TEXT;
                if (in_byte == ChBslash && !in_last) begin
                    mode_next = MODE_ESC;
                end else begin
                    bnd.data[0] = in_byte;
                    bnd.count   = 3'd1;
                end
            end
        endcase
        if (in_last) begin
            mode_next = MODE_TEXT;
            seen_next = 2'd0;
            acc_next  = 12'd0;
        end
    end

    assign push      = accept && (bnd.count != 3'd0 || in_last);
    assign push_data = bnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            seen_reg <= 2'd0;
            acc_reg  <= 12'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hex_wr) begin
            hex_reg[seen_reg] <= in_byte;
        end
    end

endmodule

>>> rtl/core/jsu_queue.sv
// Short bundle queue between the decoding front and the output back end.
`timescale 1ns / 1ps

module jsu_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jsu_pkg::bundle_t push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output jsu_pkg::bundle_t pop_data
);

    jsu_pkg::bundle_t                  mem_reg [jsu_pkg::QueueDepth];
    logic [jsu_pkg::QueueAw-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::QueueCw-1:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    assign push_ready = count_reg != jsu_pkg::QueueCw'(jsu_pkg::QueueDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == jsu_pkg::QueueAw'(jsu_pkg::QueueDepth - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == jsu_pkg::QueueAw'(jsu_pkg::QueueDepth - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/jsu_back.sv
// Output stage: walks a bundle one byte per transaction into a registered output.
`timescale 1ns / 1ps

module jsu_back (
    input  logic             aclk,
    input  logic             aresetn,
    output logic             pop,
    input  logic             pop_valid,
    input  jsu_pkg::bundle_t pop_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_byte_valid,
    output logic             out_run_last,
    output logic             out_string_end
);

    jsu_pkg::bundle_t cur_reg;
    logic             cur_valid_reg;
    logic [1:0]       idx_reg;
    logic             oval_reg;
    logic [7:0]       obyte_reg;
    logic             obv_reg, orl_reg, ose_reg;
    logic [1:0]       last_idx;
    logic             at_end, adv, cur_done;

    assign last_idx = (cur_reg.count == 3'd0) ? 2'd0 : 2'(cur_reg.count - 3'd1);
    assign at_end   = idx_reg == last_idx;
    assign adv      = cur_valid_reg && (!oval_reg || out_ready);
    assign cur_done = adv && at_end;
    assign pop      = pop_valid && (!cur_valid_reg || cur_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            oval_reg      <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (cur_done) begin
                cur_valid_reg <= 1'b0;
            end else if (adv) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (adv) begin
                oval_reg <= 1'b1;
            end else if (out_ready) begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_data;
        end
        if (adv) begin
            obyte_reg <= (cur_reg.count == 3'd0) ? 8'd0 : cur_reg.data[idx_reg];
            obv_reg   <= cur_reg.count != 3'd0;
            orl_reg   <= at_end;
            ose_reg   <= at_end && cur_reg.last;
        end
    end

    assign out_valid      = oval_reg;
    assign out_byte       = obyte_reg;
    assign out_byte_valid = obv_reg;
    assign out_run_last   = orl_reg;
    assign out_string_end = ose_reg;

endmodule

>>> rtl/core/json_string_unescaper.sv
// Top level of the streaming JSON string-body unescaper.
// Path: an accepted byte's bundle goes through the queue, the current-bundle
// register and the output register. Throughput: one input byte per cycle while
// the queue has room; a byte that yields several results holds the output for
// one transaction per result, and a two-entry bundle queue absorbs the
// difference. Reset (aresetn low, synchronous) returns the decoder to plain
// text mode and empties the queue and output register.
`timescale 1ns / 1ps

module json_string_unescaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] string_end
    output logic       m_tlast    // run_last
);

    logic             push, push_ready, pop, pop_valid;
    jsu_pkg::bundle_t push_data, pop_data;
    logic             bv, se;

    jsu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push),
        .push_data   (push_data),
        .queue_ready (push_ready)
    );

    jsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    jsu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop            (pop),
        .pop_valid      (pop_valid),
        .pop_data       (pop_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_byte_valid (bv),
        .out_run_last   (m_tlast),
        .out_string_end (se)
    );

    assign m_tuser = {se, bv};

endmodule
